/* rtl/core/s5ch_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the SOCKS5 client handshake controller.
// No dependencies; every module in rtl/core imports this package.
package s5ch_pkg;

    localparam int unsigned LEN_W = 9;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_RX    = 2'd1,
        KIND_WDONE = 2'd2,
        KIND_FAULT = 2'd3
    } kind_t;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_GREET   = 3'd1;
    localparam logic [2:0] CMD_AUTH    = 3'd2;
    localparam logic [2:0] CMD_CONNECT = 3'd3;
    localparam logic [2:0] CMD_FINISH  = 3'd4;

    localparam logic [4:0] ST_OK      = 5'd0;
    localparam logic [4:0] ST_FAULT   = 5'd1;
    localparam logic [4:0] ST_WRITE   = 5'd2;
    localparam logic [4:0] ST_METHOD  = 5'd3;
    localparam logic [4:0] ST_USER    = 5'd4;
    localparam logic [4:0] ST_PASS    = 5'd5;
    localparam logic [4:0] ST_AUTH    = 5'd6;
    localparam logic [4:0] ST_HOST    = 5'd7;
    localparam logic [4:0] ST_INVALID = 5'd8;

    localparam logic [1:0] CFG_USE_BASIC_AUTH = 2'd0;
    localparam logic [1:0] CFG_USER_LEN       = 2'd1;
    localparam logic [1:0] CFG_PASS_LEN       = 2'd2;
    localparam logic [1:0] CFG_HOST_LEN       = 2'd3;

    localparam logic [7:0] SOCKS_VER      = 8'h05;
    localparam logic [7:0] BASIC_VER      = 8'h01;
    localparam logic [7:0] METH_NO_AUTH   = 8'h00;
    localparam logic [7:0] METH_USER_PASS = 8'h02;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_NAME      = 8'h03;
    localparam logic [7:0] ATYP_IPV6      = 8'h04;
    localparam logic [7:0] REP_MAX        = 8'h08;
    localparam logic [LEN_W-1:0] LEN_LIMIT  = 9'd255;
    localparam logic [LEN_W-1:0] IPV4_LEFT  = 9'd6;
    localparam logic [LEN_W-1:0] IPV6_LEFT  = 9'd18;
    localparam logic [LEN_W-1:0] PORT_BYTES = 9'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic       write_ok;
    } in_item_t;

    typedef struct packed {
        logic [2:0] command;
        logic [4:0] status;
    } out_item_t;

    typedef struct packed {
        logic             use_basic_auth;
        logic [LEN_W-1:0] user_len;
        logic [LEN_W-1:0] pass_len;
        logic [LEN_W-1:0] host_len;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_res_t;

endpackage

/* rtl/core/s5ch_core.sv */
`timescale 1ns / 1ps
// Handshake sequencer: holds the protocol state and computes the result of
// one request per step. Depends on s5ch_pkg.
module s5ch_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  s5ch_pkg::in_item_t item,
    input  s5ch_pkg::cfg_t    cfg,
    output s5ch_pkg::step_res_t res
);
    import s5ch_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_GREET_WR, PH_METHOD_RD, PH_AUTH_WR, PH_AUTH_RD,
        PH_CONN_WR, PH_REPLY_RD, PH_LEN_RD, PH_ADDR_RD, PH_DONE
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [1:0]       byte_count_reg, byte_count_next;
    logic [7:0]       reply_code_reg, reply_code_next;
    logic             header_bad_reg, header_bad_next;
    logic [LEN_W-1:0] bytes_left_reg, bytes_left_next;

    logic [7:0]       method;
    logic [7:0]       b;
    logic [LEN_W-1:0] left_dec;

    assign b        = item.rx_byte;
    assign method   = cfg.use_basic_auth ? METH_USER_PASS : METH_NO_AUTH;
    assign left_dec = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        reply_code_next = reply_code_reg;
        header_bad_next = header_bad_reg;
        bytes_left_next = bytes_left_reg;
        res.valid        = 1'b0;
        res.item.command = CMD_NONE;
        res.item.status  = ST_OK;

        case (kind_t'(item.kind))
            KIND_START:
            begin
                byte_count_next  = '0;
                header_bad_next  = 1'b0;
                reply_code_next  = '0;
                bytes_left_next  = '0;
                phase_next       = PH_GREET_WR;
                res.valid        = 1'b1;
                res.item.command = CMD_GREET;
            end

            KIND_RX:
            begin
                case (phase_reg)
                    PH_METHOD_RD:
                    begin
                        if (byte_count_reg == 2'd0)
                        begin
                            header_bad_next = (b != SOCKS_VER);
                            byte_count_next = 2'd1;
                        end
                        else
                        begin
                            res.valid        = 1'b1;
                            res.item.command = CMD_FINISH;
                            phase_next       = PH_DONE;
                            if (header_bad_reg || b != method)
                                res.item.status = ST_METHOD;
                            else if (!cfg.use_basic_auth)
                            begin
                                if (cfg.host_len > LEN_LIMIT)
                                    res.item.status = ST_HOST;
                                else
                                begin
                                    phase_next       = PH_CONN_WR;
                                    res.item.command = CMD_CONNECT;
                                end
                            end
                            else if (cfg.user_len > LEN_LIMIT)
                                res.item.status = ST_USER;
                            else if (cfg.pass_len > LEN_LIMIT)
                                res.item.status = ST_PASS;
                            else
                            begin
                                phase_next       = PH_AUTH_WR;
                                res.item.command = CMD_AUTH;
                            end
                        end
                    end

                    PH_AUTH_RD:
                    begin
                        if (byte_count_reg == 2'd0)
                        begin
                            header_bad_next = (b != BASIC_VER);
                            byte_count_next = 2'd1;
                        end
                        else
                        begin
                            res.valid        = 1'b1;
                            res.item.command = CMD_FINISH;
                            phase_next       = PH_DONE;
                            if (header_bad_reg || b != 8'h00)
                                res.item.status = ST_AUTH;
                            else if (cfg.host_len > LEN_LIMIT)
                                res.item.status = ST_HOST;
                            else
                            begin
                                phase_next       = PH_CONN_WR;
                                res.item.command = CMD_CONNECT;
                            end
                        end
                    end

                    PH_REPLY_RD:
                    begin
                        if (byte_count_reg == 2'd3)
                        begin
                            // address type byte: report failure, pick the skip length or read the name length
                            if (header_bad_reg)
                            begin
                                res.valid = 1'b1;
                                res.item.status = ST_INVALID;
                            end
                            else if (reply_code_reg != 8'h00)
                            begin
                                res.valid = 1'b1;
                                res.item.status = (reply_code_reg <= REP_MAX)
                                    ? ST_INVALID + reply_code_reg[4:0]
                                    : ST_INVALID + 5'd1;
                            end
                            else if (b == ATYP_IPV4)
                            begin
                                bytes_left_next = IPV4_LEFT;
                                phase_next      = PH_ADDR_RD;
                            end
                            else if (b == ATYP_IPV6)
                            begin
                                bytes_left_next = IPV6_LEFT;
                                phase_next      = PH_ADDR_RD;
                            end
                            else if (b == ATYP_NAME)
                                phase_next = PH_LEN_RD;
                            else
                            begin
                                res.valid = 1'b1;
                                res.item.status = ST_INVALID;
                            end
                            if (res.valid)
                            begin
                                res.item.command = CMD_FINISH;
                                phase_next       = PH_DONE;
                            end
                        end
                        else
                        begin
                            if (byte_count_reg == 2'd0)
                                header_bad_next = (b != SOCKS_VER);
                            else if (byte_count_reg == 2'd1)
                                reply_code_next = b;
                            else if (b != 8'h00)
                                header_bad_next = 1'b1;
                            byte_count_next = byte_count_reg + 2'd1;
                        end
                    end

                    PH_LEN_RD:
                    begin
                        bytes_left_next = {1'b0, b} + PORT_BYTES;
                        phase_next      = PH_ADDR_RD;
                    end

                    PH_ADDR_RD:
                    begin
                        bytes_left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            res.valid        = 1'b1;
                            res.item.command = CMD_FINISH;
                            phase_next       = PH_DONE;
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            KIND_WDONE:
            begin
                if (phase_reg == PH_GREET_WR || phase_reg == PH_AUTH_WR ||
                    phase_reg == PH_CONN_WR)
                begin
                    if (!item.write_ok)
                    begin
                        res.valid        = 1'b1;
                        res.item.command = CMD_FINISH;
                        res.item.status  = ST_WRITE;
                        phase_next       = PH_DONE;
                    end
                    else
                    begin
                        byte_count_next = '0;
                        header_bad_next = 1'b0;
                        if (phase_reg == PH_GREET_WR)
                            phase_next = PH_METHOD_RD;
                        else if (phase_reg == PH_AUTH_WR)
                            phase_next = PH_AUTH_RD;
                        else
                            phase_next = PH_REPLY_RD;
                    end
                end
            end

            default:
            begin
                // link fault ends an active handshake only
                if (phase_reg != PH_IDLE && phase_reg != PH_DONE)
                begin
                    res.valid        = 1'b1;
                    res.item.command = CMD_FINISH;
                    res.item.status  = ST_FAULT;
                    phase_next       = PH_DONE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= '0;
            reply_code_reg <= '0;
            header_bad_reg <= 1'b0;
            bytes_left_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            reply_code_reg <= reply_code_next;
            header_bad_reg <= header_bad_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

/* rtl/core/socks5_client_handshake.sv */
`timescale 1ns / 1ps
// SOCKS5 client handshake controller: top level with input and result
// registers and configuration. Depends on s5ch_pkg and s5ch_core.
//
// Usage:
//   in_valid/in_ready carry one request (start, received byte, write done or
//   link fault). out_valid/out_ready carry the command for the transmitter
//   (greeting, authentication, connect) or the finish status.
//   cfg_we/cfg_index/cfg_data write the method and length registers; write
//   them only while no handshake request is in flight.
//   A request is registered on accept and processed from the input register;
//   its result, if any, passes through the result register to out_valid.
//   Throughput: one request per cycle while the result register is free,
//   set by the s5ch_core state update between the input and result registers.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more request, then in_ready drops until the result
//   register frees.
//   Reset clears the configuration, empties both registers and returns the
//   sequencer to idle.
module socks5_client_handshake (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  s5ch_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output s5ch_pkg::out_item_t  out_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [s5ch_pkg::LEN_W-1:0] cfg_data
);
    import s5ch_pkg::*;

    cfg_t      cfg_reg;
    in_item_t  item_reg;
    logic      item_vld_reg;
    out_item_t res_reg;
    logic      res_vld_reg;
    step_res_t step_res;
    logic      step_en;
    logic      res_free;

    assign res_free  = !res_vld_reg || out_ready;
    assign step_en   = item_vld_reg && res_free;
    assign in_ready  = !item_vld_reg || res_free;
    assign out_valid = res_vld_reg;
    assign out_item  = res_reg;

    s5ch_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_USE_BASIC_AUTH: cfg_reg.use_basic_auth <= cfg_data[0];
                CFG_USER_LEN:       cfg_reg.user_len       <= cfg_data;
                CFG_PASS_LEN:       cfg_reg.pass_len       <= cfg_data;
                CFG_HOST_LEN:       cfg_reg.host_len       <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_vld_reg <= in_valid;
            if (res_free)
                res_vld_reg <= step_en && step_res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
        if (step_en && step_res.valid && res_free)
            res_reg <= step_res.item;
    end

endmodule
